/* sv/fqc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fqc_pkg
// shared constants and types for the fragment quality checker
// ----------------------------------------------------------------------------
package fqc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_CHECK_ENABLE      = 2'd0;
    localparam logic [1:0] REG_ENCODING_CHECK_ON = 2'd1;
    localparam logic [1:0] REG_LENGTH_LIMIT      = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // saturation limits
    localparam logic [5:0]  MAX_ISSUES = 6'd32;
    localparam logic [15:0] CNT16_MAX  = 16'hFFFF;
    localparam logic [16:0] BYTES_MAX  = 17'h1FFFF;

    // utf-8 classification masks and patterns
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;

    // one result item
    typedef struct packed {
        logic [15:0] fragment_number;
        logic        empty_flag;
        logic        too_long_flag;
        logic        bad_encoding_flag;
        logic        fragment_ok;
        logic [15:0] checked_total;
        logic [15:0] passed_total;
        logic [5:0]  issues_total;
        logic        batch_ok;
        logic        batch_last;
    } fqc_result_t;

endpackage
`default_nettype wire

/* sv/fragment_quality_checker.sv */
`default_nettype none
// result path: the item that ends a fragment is first taken into the input register,
// then the pass loads the result register from it once the result register is free
// throughput: one byte item per cycle, set by the single pass from input to result register
// a stalled result register holds back only items that end a fragment
// reset (aresetn low at a clock edge) clears the configuration, all counters and both valids
// ----------------------------------------------------------------------------
// fragment_quality_checker
// streaming empty / length / lax utf-8 check of text fragments with batch totals
// ----------------------------------------------------------------------------
module fragment_quality_checker
    import fqc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // byte stream in
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_text_byte,
    input  wire logic                  s_has_byte,
    input  wire logic                  s_fragment_end,
    input  wire logic                  s_batch_end,

    // per-fragment results out
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [15:0]                m_fragment_number,
    output logic                       m_empty_flag,
    output logic                       m_too_long_flag,
    output logic                       m_bad_encoding_flag,
    output logic                       m_fragment_ok,
    output logic [15:0]                m_checked_total,
    output logic [15:0]                m_passed_total,
    output logic [5:0]                 m_issues_total,
    output logic                       m_batch_ok,
    output logic                       m_batch_last
);

    // configuration registers
    logic        check_en_reg;
    logic        enc_check_reg;
    logic [15:0] len_limit_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_has_reg;
    logic        in_fend_reg;
    logic        in_bend_reg;

    // per-fragment and per-batch state
    logic [15:0] frag_cnt_reg,   frag_cnt_next;
    logic [16:0] byte_cnt_reg,   byte_cnt_next;
    logic [1:0]  pend_reg,       pend_next;
    logic        enc_fail_reg,   enc_fail_next;
    logic [15:0] passed_cnt_reg, passed_cnt_next;
    logic [5:0]  issue_cnt_reg,  issue_cnt_next;

    // result register
    logic        out_valid_reg;
    fqc_result_t out_reg, out_next;

    // control
    logic out_free;
    logic advance;
    logic load_in;
    logic emit;

    // working values for the fragment close
    logic [16:0] byte_cnt_upd;
    logic [1:0]  pend_upd;
    logic        enc_fail_upd;
    logic        empty_w;
    logic        too_long_w;
    logic        bad_w;
    logic        ok_w;
    logic [1:0]  new_issues;
    logic [6:0]  issue_sum;
    logic [5:0]  issue_upd;
    logic [15:0] checked_w;
    logic [15:0] passed_upd;

    // the result register takes a new result when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    // a byte that does not end its fragment never waits for the result side
    assign advance  = in_valid_reg && (!in_fend_reg || out_free);
    assign emit     = advance && in_fend_reg;
    assign s_ready  = !in_valid_reg || advance;
    assign load_in  = s_valid && s_ready;

    // byte count and utf-8 tracker after the held item
    always_comb begin
        byte_cnt_upd = byte_cnt_reg;
        pend_upd     = pend_reg;
        enc_fail_upd = enc_fail_reg;
        if (in_has_reg) begin
            if (byte_cnt_reg != BYTES_MAX) begin
                byte_cnt_upd = 17'(byte_cnt_reg + 17'd1);
            end
            // once failed the fragment stays failed
            if (!enc_fail_reg) begin
                if (pend_reg != 2'd0) begin
                    if ((in_byte_reg & CONT_MASK) == CONT_PAT) begin
                        pend_upd = 2'(pend_reg - 2'd1);
                    end else begin
                        enc_fail_upd = 1'b1;
                    end
                end else if (!in_byte_reg[7]) begin
                    // plain ascii
                end else if ((in_byte_reg & LEAD2_MASK) == LEAD2_PAT) begin
                    // c0 and c1 can only start overlong forms
                    if (in_byte_reg < LEAD2_MIN) begin
                        enc_fail_upd = 1'b1;
                    end else begin
                        pend_upd = 2'd1;
                    end
                end else if ((in_byte_reg & LEAD3_MASK) == LEAD3_PAT) begin
                    pend_upd = 2'd2;
                end else if ((in_byte_reg & LEAD4_MASK) == LEAD4_PAT) begin
                    pend_upd = 2'd3;
                end else begin
                    // stray continuation or f8 and above
                    enc_fail_upd = 1'b1;
                end
            end
        end
    end

    // fragment verdict and running totals
    always_comb begin
        empty_w    = 1'b0;
        too_long_w = 1'b0;
        bad_w      = 1'b0;
        if (check_en_reg) begin
            empty_w    = (byte_cnt_upd == 17'd0);
            too_long_w = (len_limit_reg != 16'd0) && (byte_cnt_upd > {1'b0, len_limit_reg});
            bad_w      = enc_check_reg && (byte_cnt_upd != 17'd0)
                         && (enc_fail_upd || (pend_upd != 2'd0));
        end
        ok_w = !(empty_w || too_long_w || bad_w);

        // adding one at a time with a cap is the same as a capped sum
        new_issues = 2'({1'b0, empty_w} + {1'b0, too_long_w} + {1'b0, bad_w});
        issue_sum  = {1'b0, issue_cnt_reg} + {5'd0, new_issues};
        issue_upd  = (issue_sum > {1'b0, MAX_ISSUES}) ? MAX_ISSUES : issue_sum[5:0];

        checked_w  = (frag_cnt_reg != CNT16_MAX) ? 16'(frag_cnt_reg + 16'd1) : CNT16_MAX;
        passed_upd = (ok_w && (passed_cnt_reg != CNT16_MAX))
                     ? 16'(passed_cnt_reg + 16'd1) : passed_cnt_reg;

        out_next.fragment_number   = frag_cnt_reg;
        out_next.empty_flag        = empty_w;
        out_next.too_long_flag     = too_long_w;
        out_next.bad_encoding_flag = bad_w;
        out_next.fragment_ok       = ok_w;
        out_next.checked_total     = checked_w;
        out_next.passed_total      = passed_upd;
        out_next.issues_total      = issue_upd;
        out_next.batch_ok          = (issue_upd == 6'd0);
        out_next.batch_last        = in_bend_reg;
    end

    // next state: fragment state clears at every fragment end, batch totals at batch end
    always_comb begin
        byte_cnt_next   = byte_cnt_reg;
        pend_next       = pend_reg;
        enc_fail_next   = enc_fail_reg;
        frag_cnt_next   = frag_cnt_reg;
        passed_cnt_next = passed_cnt_reg;
        issue_cnt_next  = issue_cnt_reg;
        if (advance) begin
            if (in_fend_reg) begin
                byte_cnt_next = 17'd0;
                pend_next     = 2'd0;
                enc_fail_next = 1'b0;
                if (in_bend_reg) begin
                    frag_cnt_next   = 16'd0;
                    passed_cnt_next = 16'd0;
                    issue_cnt_next  = 6'd0;
                end else begin
                    frag_cnt_next   = checked_w;
                    passed_cnt_next = passed_upd;
                    issue_cnt_next  = issue_upd;
                end
            end else begin
                byte_cnt_next = byte_cnt_upd;
                pend_next     = pend_upd;
                enc_fail_next = enc_fail_upd;
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_en_reg   <= 1'b0;
            enc_check_reg  <= 1'b0;
            len_limit_reg  <= 16'd0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            frag_cnt_reg   <= 16'd0;
            byte_cnt_reg   <= 17'd0;
            pend_reg       <= 2'd0;
            enc_fail_reg   <= 1'b0;
            passed_cnt_reg <= 16'd0;
            issue_cnt_reg  <= 6'd0;
        end else begin
            // configuration writes, unknown indexes are dropped
            if (cfg_we) begin
                if (cfg_idx == REG_CHECK_ENABLE) begin
                    check_en_reg <= cfg_data[0];
                end else if (cfg_idx == REG_ENCODING_CHECK_ON) begin
                    enc_check_reg <= cfg_data[0];
                end else if (cfg_idx == REG_LENGTH_LIMIT) begin
                    len_limit_reg <= cfg_data;
                end
            end

            if (load_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            frag_cnt_reg   <= frag_cnt_next;
            byte_cnt_reg   <= byte_cnt_next;
            pend_reg       <= pend_next;
            enc_fail_reg   <= enc_fail_next;
            passed_cnt_reg <= passed_cnt_next;
            issue_cnt_reg  <= issue_cnt_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_byte_reg <= s_text_byte;
            in_has_reg  <= s_has_byte;
            in_fend_reg <= s_fragment_end;
            in_bend_reg <= s_batch_end;
        end
        if (emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_fragment_number   = out_reg.fragment_number;
    assign m_empty_flag        = out_reg.empty_flag;
    assign m_too_long_flag     = out_reg.too_long_flag;
    assign m_bad_encoding_flag = out_reg.bad_encoding_flag;
    assign m_fragment_ok       = out_reg.fragment_ok;
    assign m_checked_total     = out_reg.checked_total;
    assign m_passed_total      = out_reg.passed_total;
    assign m_issues_total      = out_reg.issues_total;
    assign m_batch_ok          = out_reg.batch_ok;
    assign m_batch_last        = out_reg.batch_last;

`ifndef SYNTHESIS
    // issue total never runs past the cap
    a_issue_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_cnt_reg <= MAX_ISSUES)
        else $error("issue counter above cap");

    // a fragment is ok exactly when no flag is raised
    a_ok_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fragment_ok ==
            !(m_empty_flag || m_too_long_flag || m_bad_encoding_flag)))
        else $error("fragment_ok disagrees with flags");

    // passed fragments never outnumber checked ones
    a_passed_le_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_passed_total <= m_checked_total))
        else $error("passed total above checked total");

    // a result that closes a batch leaves the batch totals cleared
    a_batch_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && in_bend_reg |=> (frag_cnt_reg == 16'd0) && (issue_cnt_reg == 6'd0)
            && (passed_cnt_reg == 16'd0))
        else $error("batch totals not cleared at batch end");

    // a pending result is held until its transfer
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(out_reg))
        else $error("result dropped or changed while stalled");
`endif

endmodule
`default_nettype wire

/* verif/fqc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fqc_checker
// Watches the configuration port and both channels of the fragment quality
// checker. It keeps its own copy of the fragment and batch counters, works
// out the report due for every fragment end, and compares the reports that
// come out field by field in order.
// ----------------------------------------------------------------------------
module fqc_checker
    import fqc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [7:0]            s_text_byte,
    input  wire logic                  s_has_byte,
    input  wire logic                  s_fragment_end,
    input  wire logic                  s_batch_end,

    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [15:0]           m_fragment_number,
    input  wire logic                  m_empty_flag,
    input  wire logic                  m_too_long_flag,
    input  wire logic                  m_bad_encoding_flag,
    input  wire logic                  m_fragment_ok,
    input  wire logic [15:0]           m_checked_total,
    input  wire logic [15:0]           m_passed_total,
    input  wire logic [5:0]            m_issues_total,
    input  wire logic                  m_batch_ok,
    input  wire logic                  m_batch_last,

    output int                         mismatch_count,
    output int                         reports_due
);

    // keeps a broken run from flooding the log
    localparam int REPORT_CAP = 100;

    // configuration copy
    logic        checking_on;
    logic        utf8_check_on;
    logic [15:0] max_length;

    // fragment and batch state
    logic [15:0] fragments_seen;
    logic [16:0] bytes_in_fragment;
    logic [1:0]  continuations_left;
    logic        utf8_broken;
    logic [15:0] passes_seen;
    logic [5:0]  issues_seen;

    fqc_result_t due_reports[$];
    fqc_result_t oldest;
    int          mismatches;

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            if (mismatches < REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // lax utf-8 state machine, one byte at a time
    function automatic void feed_utf8(input logic [7:0] b);
        if (!utf8_broken) begin
            if (continuations_left != 2'd0) begin
                if ((b & CONT_MASK) == CONT_PAT)
                    continuations_left = continuations_left - 2'd1;
                else
                    utf8_broken = 1'b1;
            end else if (b[7]) begin
                if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                    // c0 and c1 can only start overlong forms
                    if (b < LEAD2_MIN)
                        utf8_broken = 1'b1;
                    else
                        continuations_left = 2'd1;
                end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                    continuations_left = 2'd2;
                end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                    continuations_left = 2'd3;
                end else begin
                    utf8_broken = 1'b1;
                end
            end
        end
    endfunction

    // report for the fragment that ends now; registers are read here
    function automatic fqc_result_t close_fragment(input logic last);
        fqc_result_t r;
        logic        is_empty;
        logic        over;
        logic        enc_bad;
        r        = '0;
        is_empty = checking_on && bytes_in_fragment == 17'd0;
        over     = checking_on && max_length != 16'd0 &&
                   bytes_in_fragment > {1'b0, max_length};
        enc_bad  = checking_on && utf8_check_on && bytes_in_fragment != 17'd0 &&
                   (utf8_broken || continuations_left != 2'd0);
        if (is_empty && issues_seen < MAX_ISSUES)
            issues_seen++;
        if (over && issues_seen < MAX_ISSUES)
            issues_seen++;
        if (enc_bad && issues_seen < MAX_ISSUES)
            issues_seen++;

        r.fragment_number   = fragments_seen;
        r.empty_flag        = is_empty;
        r.too_long_flag     = over;
        r.bad_encoding_flag = enc_bad;
        r.fragment_ok       = !(is_empty || over || enc_bad);
        if (fragments_seen != CNT16_MAX)
            fragments_seen++;
        r.checked_total = fragments_seen;
        if (r.fragment_ok && passes_seen != CNT16_MAX)
            passes_seen++;
        r.passed_total = passes_seen;
        r.issues_total = issues_seen;
        r.batch_ok     = (issues_seen == 6'd0);
        r.batch_last   = last;

        bytes_in_fragment  = '0;
        continuations_left = '0;
        utf8_broken        = 1'b0;
        if (last) begin
            fragments_seen = '0;
            passes_seen    = '0;
            issues_seen    = '0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            checking_on        = 1'b0;
            utf8_check_on      = 1'b0;
            max_length         = '0;
            fragments_seen     = '0;
            bytes_in_fragment  = '0;
            continuations_left = '0;
            utf8_broken        = 1'b0;
            passes_seen        = '0;
            issues_seen        = '0;
            due_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_CHECK_ENABLE:      checking_on   = cfg_data[0];
                    REG_ENCODING_CHECK_ON: utf8_check_on = cfg_data[0];
                    REG_LENGTH_LIMIT:      max_length    = cfg_data[15:0];
                    default: begin
                    end
                endcase
            end

            // reports leave only after their fragment end has passed the input and result registers,
            // so comparing before predicting is safe
            if (m_valid && m_ready) begin
                if (due_reports.size() == 0) begin
                    if (mismatches < REPORT_CAP)
                        $error("report with none due: fragment_number %0d",
                               m_fragment_number);
                    mismatches++;
                end else begin
                    oldest = due_reports.pop_front();
                    compare_field("fragment_number", oldest.fragment_number,
                                  m_fragment_number);
                    compare_field("empty_flag", 16'(oldest.empty_flag),
                                  16'(m_empty_flag));
                    compare_field("too_long_flag", 16'(oldest.too_long_flag),
                                  16'(m_too_long_flag));
                    compare_field("bad_encoding_flag", 16'(oldest.bad_encoding_flag),
                                  16'(m_bad_encoding_flag));
                    compare_field("fragment_ok", 16'(oldest.fragment_ok),
                                  16'(m_fragment_ok));
                    compare_field("checked_total", oldest.checked_total,
                                  m_checked_total);
                    compare_field("passed_total", oldest.passed_total,
                                  m_passed_total);
                    compare_field("issues_total", 16'(oldest.issues_total),
                                  16'(m_issues_total));
                    compare_field("batch_ok", 16'(oldest.batch_ok), 16'(m_batch_ok));
                    compare_field("batch_last", 16'(oldest.batch_last),
                                  16'(m_batch_last));
                end
            end

            if (s_valid && s_ready) begin
                if (s_has_byte) begin
                    if (bytes_in_fragment != BYTES_MAX)
                        bytes_in_fragment++;
                    feed_utf8(s_text_byte);
                end
                if (s_fragment_end)
                    due_reports.push_back(close_fragment(s_batch_end));
            end
        end
        mismatch_count <= mismatches;
        reports_due    <= due_reports.size();
    end

endmodule
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the fragment quality checker. A short directed
// part walks the utf-8 corner cases, empty and over-long fragments and batch
// handling; random phases then send mostly well-formed text with broken
// sequences mixed in, under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb
    import fqc_pkg::*;
;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 100000;

    // items per random phase, and number of phases
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES      = 8;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_text_byte    = '0;
    logic                  s_has_byte     = 1'b0;
    logic                  s_fragment_end = 1'b0;
    logic                  s_batch_end    = 1'b0;

    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic [15:0]           m_fragment_number;
    logic                  m_empty_flag;
    logic                  m_too_long_flag;
    logic                  m_bad_encoding_flag;
    logic                  m_fragment_ok;
    logic [15:0]           m_checked_total;
    logic [15:0]           m_passed_total;
    logic [5:0]            m_issues_total;
    logic                  m_batch_ok;
    logic                  m_batch_last;

    int                    mismatch_count;
    int                    reports_due;

    // idling, in percent of cycles
    int                    send_idle_pct = 0;
    int                    stall_pct     = 0;
    // transfers that carry a byte or end a fragment
    int                    items_sent    = 0;
    int                    cycle_count   = 0;

    fragment_quality_checker dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_idx             (cfg_idx),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_text_byte         (s_text_byte),
        .s_has_byte          (s_has_byte),
        .s_fragment_end      (s_fragment_end),
        .s_batch_end         (s_batch_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_fragment_number   (m_fragment_number),
        .m_empty_flag        (m_empty_flag),
        .m_too_long_flag     (m_too_long_flag),
        .m_bad_encoding_flag (m_bad_encoding_flag),
        .m_fragment_ok       (m_fragment_ok),
        .m_checked_total     (m_checked_total),
        .m_passed_total      (m_passed_total),
        .m_issues_total      (m_issues_total),
        .m_batch_ok          (m_batch_ok),
        .m_batch_last        (m_batch_last)
    );

    fqc_checker chk (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_idx             (cfg_idx),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_text_byte         (s_text_byte),
        .s_has_byte          (s_has_byte),
        .s_fragment_end      (s_fragment_end),
        .s_batch_end         (s_batch_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_fragment_number   (m_fragment_number),
        .m_empty_flag        (m_empty_flag),
        .m_too_long_flag     (m_too_long_flag),
        .m_bad_encoding_flag (m_bad_encoding_flag),
        .m_fragment_ok       (m_fragment_ok),
        .m_checked_total     (m_checked_total),
        .m_passed_total      (m_passed_total),
        .m_issues_total      (m_issues_total),
        .m_batch_ok          (m_batch_ok),
        .m_batch_last        (m_batch_last),
        .mismatch_count      (mismatch_count),
        .reports_due         (reports_due)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // one register write; always starts on a fresh edge so cfg_we never
    // gets two assignments in one step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we   <= 1'b0;
    endtask

    // enable writes carry random upper bits, which the block must ignore
    task automatic set_config(input logic en, input logic enc, input logic [15:0] lim);
        write_reg(REG_CHECK_ENABLE, {15'($urandom_range(0, 32767)), en});
        write_reg(REG_ENCODING_CHECK_ON, {15'($urandom_range(0, 32767)), enc});
        write_reg(REG_LENGTH_LIMIT, lim);
    endtask

    // one transfer on the byte stream, with a random idle gap in front;
    // returns on the edge that accepts it, valid still high
    task automatic send_item(input logic [7:0] b, input logic has,
                             input logic fend, input logic bend);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_text_byte    <= b;
        s_has_byte     <= has;
        s_fragment_end <= fend;
        s_batch_end    <= bend;
        do @(posedge aclk); while (!s_ready);
        if (has || fend)
            items_sent++;
    endtask

    // stop sending and wait for every report due, then let the pipeline empty;
    // called on the edge of the last transfer or later
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // one random fragment: mostly valid utf-8 characters, some broken ones
    task automatic send_fragment(input logic last);
        logic [7:0] seq[4];
        int         len;
        int         n_chars;
        int         kind;
        logic       sep_end;
        logic       fin;
        if ($urandom_range(0, 99) < 8) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, last);
        end else begin
            n_chars = $urandom_range(1, 6);
            // now and then the end comes as a separate item without a byte
            sep_end = ($urandom_range(0, 9) == 0);
            for (int c = 0; c < n_chars; c++) begin
                kind = $urandom_range(0, 99);
                seq[1] = cont_byte();
                seq[2] = cont_byte();
                seq[3] = cont_byte();
                if (kind < 55) begin
                    seq[0] = 8'($urandom_range(0, 127));
                    len = 1;
                end else if (kind < 70) begin
                    seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
                    len = 2;
                end else if (kind < 80) begin
                    seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
                    len = 3;
                end else if (kind < 88) begin
                    seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
                    len = 4;
                end else if (kind < 92) begin
                    // any byte at all
                    seq[0] = 8'($urandom_range(0, 255));
                    len = 1;
                end else if (kind < 96) begin
                    // multi-byte lead missing its last continuation
                    seq[0] = 8'($urandom_range(8'hE0, 8'hF7));
                    len = (seq[0] < 8'hF0) ? 2 : 3;
                end else if (kind < 98) begin
                    // overlong two-byte form
                    seq[0] = 8'($urandom_range(8'hC0, 8'hC1));
                    len = 2;
                end else begin
                    // stray continuation
                    seq[0] = cont_byte();
                    len = 1;
                end
                for (int j = 0; j < len; j++) begin
                    fin = !sep_end && c == n_chars - 1 && j == len - 1;
                    // batch end without fragment end is noise the block ignores
                    send_item(seq[j], 1'b1, fin,
                              fin ? last : ($urandom_range(0, 15) == 0));
                    // empty item that neither carries a byte nor ends anything
                    if (!fin && $urandom_range(0, 19) == 0)
                        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0,
                                  1'($urandom_range(0, 1)));
                end
            end
            if (sep_end)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, last);
        end
    endtask

    initial begin
        logic paused;

        // synchronous reset
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // ---------------- directed part ----------------
        // limit of two bytes sits exactly on a two-byte character
        set_config(1'b1, 1'b1, 16'd2);
        // a write to the spare index must not disturb the registers
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));

        send_item(8'h00, 1'b0, 1'b1, 1'b0);   // empty fragment
        send_item(8'h00, 1'b1, 1'b1, 1'b0);   // lowest byte, passes
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);   // highest byte, bad lead
        send_item(8'hC2, 1'b1, 1'b0, 1'b0);   // two-byte, length equals limit
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'hC0, 1'b1, 1'b0, 1'b0);   // overlong lead
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'hE0, 1'b1, 1'b0, 1'b0);   // sequence cut short at the end
        send_item(8'hA0, 1'b1, 1'b1, 1'b0);
        send_item(8'hF0, 1'b1, 1'b0, 1'b0);   // valid four-byte, but too long
        send_item(8'h90, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);   // stray continuation
        send_item(8'h00, 1'b0, 1'b0, 1'b0);   // neither byte nor end: ignored
        send_item(8'h41, 1'b1, 1'b0, 1'b1);   // batch end without fragment end
        send_item(8'h00, 1'b0, 1'b1, 1'b0);   // end without byte closes 'A'
        send_item(8'hFF, 1'b1, 1'b0, 1'b0);   // failure sticks over later bytes
        send_item(8'h41, 1'b1, 1'b1, 1'b0);
        send_item(8'hF8, 1'b1, 1'b1, 1'b1);   // bad lead, closes the batch
        // registers change while a fragment is open: read at the end
        send_item(8'h41, 1'b1, 1'b0, 1'b0);
        send_item(8'h42, 1'b1, 1'b0, 1'b0);
        send_item(8'h43, 1'b1, 1'b0, 1'b0);
        drain();
        write_reg(REG_LENGTH_LIMIT, 16'd0);
        send_item(8'h44, 1'b1, 1'b1, 1'b1);
        drain();

        // ---------------- random phases ----------------
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(1'b1, 1'b1, 16'd0);
                1: set_config(1'b1, 1'b1, 16'd1);
                2: set_config(1'b1, 1'b0, 16'd3);
                3: set_config(1'b0, 1'b1, 16'd2);
                4: set_config(1'b1, 1'b1, 16'hFFFF);
                5: set_config(1'b1, 1'b1, 16'($urandom_range(1, 8)));
                6: set_config(1'b1, 1'b1, 16'd5);
                default: set_config(1'b1, 1'b0, 16'd0);
            endcase
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 48;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 48;
                end
                default: begin
                    send_idle_pct = 20;
                    stall_pct     = 20;
                end
            endcase
            items_sent = 0;
            paused     = 1'b0;
            // long batches so that the issue count reaches its cap
            while (items_sent < PHASE_ITEMS) begin
                send_fragment($urandom_range(0, 29) == 0);
                // mid-phase pause until every report has come back
                if (!paused && items_sent >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain();
                end
            end
            drain();
        end

        if (mismatch_count == 0 && reports_due == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
